// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that a stalled transfer keeps valid high and its payload unchanged.
`define ASSERT_HOLD(label, clk, rstn, vld, rdy, data) \
  `ASSERT_CLK(label, clk, rstn, (vld) && !(rdy) |=> (vld) && $stable(data))

`endif

// ----- src/rgbdf_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbdf_pkg
// Types and constants of the RGB 3x3 diffusion filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbdf_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned PIX_W         = NUM_CH * CH_W;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned DIM_W         = 11;
  localparam int unsigned ALPHA_W       = 9;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned ROW_LIMIT     = 1024;

  localparam logic [DIM_W-1:0]   MIN_DIM          = DIM_W'(3);
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = DIM_W'(480);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE        = ALPHA_W'(256);
  localparam logic [ALPHA_W-1:0] RST_BLEND        = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_BLEND_FACTOR = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             frame_done;
  } pix_out_t;

endpackage

// ----- src/rgb_3x3_diffusion_filter.sv -----
// ----------------------------------------------------------------------------
// rgb_3x3_diffusion_filter
// Raster-order RGB stream through a 3x3 window; each interior pixel is blended
// with the mean of its eight neighbors by a programmable factor.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i/in_ready_o  | pix_in_t  (one pixel)
//   out     | output    | out_valid_o/out_ready_i| pix_out_t (interior pixel)
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Throughput is one pixel per clock while the output does not stall. The pixel
// that completes a window goes through line memory read, window shift, neighbor
// sum, blend products and output register before its result is shown.
// The line memory has no reset and needs no clearing pass, so the block takes
// pixels right after reset. A stalled output pulls the ready chain low back to
// the input in the same cycle, but empty stages still fill, so the input keeps
// moving while bubbles remain. Register writes wait until the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_3x3_diffusion_filter #(
  parameter int unsigned MAX_WIDTH = rgbdf_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rgbdf_pkg::pix_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rgbdf_pkg::pix_out_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rgbdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rgbdf_pkg::DIM_W-1:0]      cfg_data_i
);
  import rgbdf_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(MAX_WIDTH);
  localparam int unsigned MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W   = (MW_BITS > DIM_W) ? MW_BITS : DIM_W;
  localparam int unsigned SUM_W   = CH_W + 3;
  localparam int unsigned PC_W    = ALPHA_W + CH_W;
  localparam int unsigned PS_W    = ALPHA_W + SUM_W;
  localparam int unsigned ACC_W   = PS_W + 1;
  // 8 bits of alpha fraction plus 3 bits for the divide by eight
  localparam int unsigned SHIFT   = 11;

  localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(ROW_LIMIT);

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_done;
  } ctrl_t;

  // --------------------------------------------------------------------------
  // Configuration registers; writes land only while the pipeline is idle.
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   frame_width_q, frame_height_q;
  logic [ALPHA_W-1:0] blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      blend_q        <= RST_BLEND;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_BLEND_FACTOR: blend_q        <= cfg_data_i[ALPHA_W-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Clamp the frame size and saturate alpha at one.
  logic [CNT_W-1:0]   w_lim;
  logic [DIM_W-1:0]   h_lim;
  logic [ALPHA_W-1:0] alpha, inv_alpha;

  always_comb begin
    if (frame_width_q < MIN_DIM) begin
      w_lim = CNT_W'(MIN_DIM);
    end else if (CNT_W'(frame_width_q) > MAX_W) begin
      w_lim = MAX_W;
    end else begin
      w_lim = CNT_W'(frame_width_q);
    end
    if (frame_height_q < MIN_DIM) begin
      h_lim = MIN_DIM;
    end else if (frame_height_q > MAX_H) begin
      h_lim = MAX_H;
    end else begin
      h_lim = frame_height_q;
    end
    alpha     = (blend_q > ALPHA_ONE) ? ALPHA_ONE : blend_q;
    inv_alpha = ALPHA_ONE - alpha;
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item leaves.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic ld1, ld2, ld3, ld4, ld5;
  logic in_xfer, s1_fire;

  assign ld5        = !vo_q || out_ready_i;
  assign ld4        = !v4_q || ld5;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;
  assign in_xfer    = in_valid_i && ld1;
  assign s1_fire    = v1_q && ld2;

  // hold register writes while any stage is busy; alpha is used late
  assign cfg_ready_o = !(v1_q || v2_q || v3_q || v4_q || vo_q);

  // --------------------------------------------------------------------------
  // Raster position of the incoming pixel.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]  col_q, row_q;
  logic [CNT_W-1:0]  x_next, rd_idx;
  logic [DIM_W-1:0]  y_next;
  logic [ADDR_W-1:0] rd_addr;
  logic              row_end, frame_end, emit;

  always_comb begin
    x_next    = CNT_W'(col_q) + CNT_W'(1);
    y_next    = DIM_W'(row_q) + DIM_W'(1);
    row_end   = (x_next >= w_lim);
    frame_end = row_end && (y_next >= h_lim);
    emit      = (col_q >= POS_W'(2)) && (row_q >= POS_W'(2));
    rd_idx    = (CNT_W'(col_q) < MAX_W) ? CNT_W'(col_q) : (MAX_W - CNT_W'(1));
    rd_addr   = rd_idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : y_next[POS_W-1:0];
      end else begin
        col_q <= x_next[POS_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line memory read. Each entry holds {row y-2, row y-1} of its
  // column. Rows are at least three pixels long, so the write-back of an
  // entry always lands before its next read.
  // --------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]   s1_pix_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic               s1_emit_q;
  ctrl_t              s1_ctrl_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= line_mem[rd_addr];
    end
    if (s1_fire) begin
      // age the column: newer row moves to older, new pixel becomes newer
      line_mem[s1_addr_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q             <= in_data_i;
      s1_addr_q            <= rd_addr;
      s1_emit_q            <= emit;
      s1_ctrl_q.col        <= col_q - POS_W'(1);
      s1_ctrl_q.row        <= row_q - POS_W'(1);
      s1_ctrl_q.frame_done <= frame_end;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: 3x3 window shift. Row 0 is the oldest row, column 2 the newest.
  // --------------------------------------------------------------------------
  logic [2:0][2:0][PIX_W-1:0] win_q;
  ctrl_t                      s2_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_q[2*PIX_W-1:PIX_W];
      win_q[1][2] <= rd_q[PIX_W-1:0];
      win_q[2][2] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: neighbor sum and center, per color lane.
  // --------------------------------------------------------------------------
  logic [NUM_CH-1:0][SUM_W-1:0] nsum, sum_q;
  logic [NUM_CH-1:0][CH_W-1:0]  cen_q;
  ctrl_t                        s3_ctrl_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      nsum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(r == 1 && c == 1)) begin
            nsum[ch] = nsum[ch] + SUM_W'(win_q[r][c][ch*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ld3) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum_q[ch] <= nsum[ch];
        cen_q[ch] <= win_q[1][1][ch*CH_W +: CH_W];
      end
      s3_ctrl_q <= s2_ctrl_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: blend products, (1 - alpha) * center and alpha * sum.
  // --------------------------------------------------------------------------
  logic [NUM_CH-1:0][PC_W-1:0] pc_q;
  logic [NUM_CH-1:0][PS_W-1:0] ps_q;
  ctrl_t                       s4_ctrl_q;

  always_ff @(posedge clk_i) begin
    if (v3_q && ld4) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        pc_q[ch] <= PC_W'(inv_alpha) * PC_W'(cen_q[ch]);
        ps_q[ch] <= PS_W'(alpha) * PS_W'(sum_q[ch]);
      end
      s4_ctrl_q <= s3_ctrl_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: 8 * center term plus sum term, drop the fraction.
  // --------------------------------------------------------------------------
  logic [NUM_CH-1:0][ACC_W-1:0] acc;
  logic [NUM_CH-1:0][CH_W-1:0]  res_q;
  ctrl_t                        out_ctrl_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc[ch] = ACC_W'({pc_q[ch], 3'b000}) + ACC_W'(ps_q[ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && ld5) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        res_q[ch] <= acc[ch][SHIFT +: CH_W];
      end
      out_ctrl_q <= s4_ctrl_q;
    end
  end

  // Valid bits; pixels without a full window stop after the window shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q && s1_emit_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) vo_q <= v4_q;
    end
  end

  assign out_valid_o           = vo_q;
  assign out_data_o.out_col    = out_ctrl_q.col;
  assign out_data_o.out_row    = out_ctrl_q.row;
  assign out_data_o.out_red    = res_q[2];
  assign out_data_o.out_green  = res_q[1];
  assign out_data_o.out_blue   = res_q[0];
  assign out_data_o.frame_done = out_ctrl_q.frame_done;

endmodule

// ----- src/rgbdf_checker.sv -----
// ----------------------------------------------------------------------------
// rgbdf_checker
// Port-level checks of the RGB 3x3 diffusion filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgbdf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input rgbdf_pkg::pix_in_t               in_data_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input rgbdf_pkg::pix_out_t              out_data_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [rgbdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [rgbdf_pkg::DIM_W-1:0]      cfg_data_i
);
  import rgbdf_pkg::*;

  logic [CFG_IDX_W+DIM_W-1:0] cfg_word;
  logic                       out_interior;

  assign cfg_word     = {cfg_index_i, cfg_data_i};
  // never column or row zero or 1023
  assign out_interior = (out_data_o.out_col != '0) && (out_data_o.out_row != '0) &&
                        (out_data_o.out_col != '1) && (out_data_o.out_row != '1);

  // A result waiting on the output keeps its value until transferred.
  `ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, out_data_o)

  // A stalled pixel or register write keeps its payload.
  `ASSERT_HOLD(a_in_hold, clk_i, rst_ni, in_valid_i, in_ready_o, in_data_i)
  `ASSERT_HOLD(a_cfg_hold, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, cfg_word)

  // With the output register empty nothing can block the input.
  `ASSERT_CLK(a_in_ready_when_drained, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // Only interior pixels leave.
  `ASSERT_CLK(a_interior_only, clk_i, rst_ni, out_valid_o |-> out_interior)

endmodule

bind rgb_3x3_diffusion_filter rgbdf_checker u_rgbdf_checker (.*);
